### src/imu_serial_frame_parser_top_macros.svh
// Assertion macros used by the frame parser top level.
`ifndef IMU_SERIAL_FRAME_PARSER_TOP_MACROS_SVH
`define IMU_SERIAL_FRAME_PARSER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clock edge outside of reset.
`define ISFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside of reset.
`define ISFP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ISFP_ASSERT(lbl, clk, rst_n, prop, msg)

`define ISFP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### src/isfp_pkg.sv
// Types and constants shared by the serial IMU frame parser.
package isfp_pkg;

    // Width of the frame byte position counter.
    localparam int unsigned POS_W = 4;

    // Last frame byte that carries value data.
    localparam int unsigned DATA_LAST_BYTE = 9;

    // Frame type byte values.
    localparam logic [7:0] TYPE_ACC        = 8'h51;
    localparam logic [7:0] TYPE_RATE       = 8'h52;
    localparam logic [7:0] TYPE_ANGLE      = 8'h53;
    localparam logic [7:0] TYPE_FIELD      = 8'h54;
    localparam logic [7:0] TYPE_QUATERNION = 8'h59;

    // Result kind codes.
    typedef enum logic [2:0] {
        KIND_ACCEL      = 3'd0,
        KIND_GYRO       = 3'd1,
        KIND_ANGLE      = 3'd2,
        KIND_MAGNETIC   = 3'd3,
        KIND_QUATERNION = 3'd4
    } kind_t;

    // One parsed frame handed from the frame core to the output register.
    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
        logic signed [15:0] value_c;
        logic signed [15:0] value_d;
        logic               motion_seen;
    } result_t;

endpackage

### src/isfp_frame_core.sv
// Frame state, running checksum and frame decode of the serial IMU parser.
module isfp_frame_core #(
    parameter int unsigned FRAME_BYTES = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       header_byte,
    output isfp_pkg::result_t result
);
    import isfp_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    logic                 in_frame_reg, in_frame_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [7:0]           sum_reg, sum_next;
    logic                 motion_reg, motion_next;
    logic [7:0]           store_reg [1:DATA_LAST_BYTE];

    logic                 last_byte;
    logic                 sum_ok;
    logic                 type_known;
    logic                 type_motion;
    kind_t                kind;

    // Decode the type byte of the frame held in the store.
    always_comb begin
        type_known  = 1'b1;
        type_motion = 1'b0;
        kind        = KIND_ACCEL;
        case (store_reg[1])
            TYPE_ACC: begin
                kind        = KIND_ACCEL;
                type_motion = 1'b1;
            end
            TYPE_RATE: begin
                kind        = KIND_GYRO;
                type_motion = 1'b1;
            end
            TYPE_ANGLE: begin
                kind        = KIND_ANGLE;
                type_motion = 1'b1;
            end
            TYPE_FIELD: begin
                kind = KIND_MAGNETIC;
            end
            TYPE_QUATERNION: begin
                kind = KIND_QUATERNION;
            end
            default: begin
                type_known = 1'b0;
            end
        endcase
    end

    assign last_byte = in_frame_reg && (pos_reg == LAST_POS);
    assign sum_ok    = (sum_reg == rx_byte);

    // Next state of the frame tracker for the current item.
    always_comb begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        motion_next   = motion_reg;
        if (!in_frame_reg) begin
            if (rx_byte == header_byte) begin
                in_frame_next = 1'b1;
                pos_next      = POS_W'(1);
                sum_next      = rx_byte;
            end
        end else if (last_byte) begin
            in_frame_next = 1'b0;
            pos_next      = '0;
            if (sum_ok && type_motion) begin
                motion_next = 1'b1;
            end
        end else begin
            pos_next = pos_reg + POS_W'(1);
            sum_next = sum_reg + rx_byte;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            motion_reg   <= 1'b0;
        end else if (step) begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            motion_reg   <= motion_next;
        end
    end

    // Frame bytes that carry the type and the values, each at its own slot.
    always_ff @(posedge aclk) begin
        for (int unsigned i = 1; i <= DATA_LAST_BYTE; i++) begin
            if (step && in_frame_reg && !last_byte && (pos_reg == POS_W'(i))) begin
                store_reg[i] <= rx_byte;
            end
        end
    end

    // Result of the frame that completes with this item.
    always_comb begin
        result.valid       = step && last_byte && sum_ok && type_known;
        result.kind        = kind;
        result.value_a     = {store_reg[3], store_reg[2]};
        result.value_b     = {store_reg[5], store_reg[4]};
        result.value_c     = {store_reg[7], store_reg[6]};
        result.value_d     = (kind == KIND_QUATERNION) ? {store_reg[9], store_reg[8]} : '0;
        result.motion_seen = motion_next;
    end

endmodule

### src/imu_serial_frame_parser_top.sv
// Top level of the serial IMU frame parser with stream ports.
// The parser takes one received byte per item and can accept a byte in every
// clock cycle while the output does not stall. A byte goes into an input register.
// From there it runs through the frame tracker and the running 8-bit sum when the
// core steps, and that edge loads a completed good frame into the output register.
// The input stalls only while a result waits in the output register and the
// receiver is not ready. The running sum register and the byte position counter
// take one byte per step, which sets the rate of one item per cycle while the
// output is not stalled. Bytes are ignored until header_byte arrives; a frame of
// FRAME_BYTES bytes then follows, and only frames with a matching checksum and a
// known type byte give a result. Values are raw little-endian signed 16-bit words.
`include "imu_serial_frame_parser_top_macros.svh"

module imu_serial_frame_parser_top #(
    parameter int unsigned FRAME_BYTES = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Header byte register.
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // Received bytes.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Parsed frames.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [15:0] value_a, [31:16] value_b, [47:32] value_c,
                                        // [63:48] value_d, [64] motion_seen, [71:65] zero
    output logic [2:0]  m_axis_tuser    // [2:0] kind
);
    import isfp_pkg::*;

    logic       header_wr;
    logic [7:0] header_byte_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    core_result;
    logic       step;

    // The header register is the only configuration register.
    assign header_wr = cfg_wr_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_byte_reg <= 8'h55;
        end else if (header_wr) begin
            header_byte_reg <= cfg_wr_data;
        end
    end

    // An item moves into the core when the output register is free or drains now.
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    isfp_frame_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .rx_byte     (in_byte_reg),
        .header_byte (header_byte_reg),
        .result      (core_result)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= core_result.valid;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && core_result.valid) begin
            out_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {7'd0, out_reg.motion_seen, out_reg.value_d, out_reg.value_c,
                            out_reg.value_b, out_reg.value_a};

    // The core never advances while a result waits in a stalled output register.
    `ISFP_ASSERT_NEVER(a_no_step_on_stall, aclk, aresetn,
        step && out_valid_reg && !m_axis_tready,
        "core advanced over a stalled result")
    // Motion frames always show the motion flag set.
    `ISFP_ASSERT(a_motion_flag, aclk, aresetn,
        out_valid_reg && (out_reg.kind == KIND_ACCEL || out_reg.kind == KIND_GYRO
            || out_reg.kind == KIND_ANGLE) |-> out_reg.motion_seen,
        "motion frame without motion flag")
    // The fourth value is only filled for quaternion frames.
    `ISFP_ASSERT(a_value_d_zero, aclk, aresetn,
        out_valid_reg && (out_reg.kind != KIND_QUATERNION) |-> (out_reg.value_d == 16'sd0),
        "value_d set for a non-quaternion frame")
    // Once reported, the sticky motion flag stays set.
    `ISFP_ASSERT(a_motion_sticky, aclk, aresetn,
        step && core_result.valid
            && $past(step && core_result.valid && core_result.motion_seen)
            |-> core_result.motion_seen,
        "motion flag cleared between frames")

endmodule
